// ===== rtl/mtep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_pkg
// Types, codes and helpers shared by the track event parser modules.
// ----------------------------------------------------------------------------
package mtep_pkg;

   localparam int unsigned LEN_W = 28;
   localparam logic [LEN_W-1:0] LEN_MAX = 28'hFFF_FFFF;

   localparam logic [7:0] ST_META    = 8'hFF;
   localparam logic [7:0] ST_SYSEX   = 8'hF0;
   localparam logic [7:0] ST_ESCAPE  = 8'hF7;
   localparam logic [7:0] META_EOT   = 8'h2F;
   localparam logic [3:0] CMD_PROG   = 4'hC;
   localparam logic [3:0] CMD_CHPRES = 4'hD;
   localparam logic [3:0] SYS_NIBBLE = 4'hF;

   localparam logic [2:0] KIND_CHAN    = 3'd0;
   localparam logic [2:0] KIND_META    = 3'd1;
   localparam logic [2:0] KIND_SYSEX   = 3'd2;
   localparam logic [2:0] KIND_PAYLOAD = 3'd3;
   localparam logic [2:0] KIND_EOT     = 3'd4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       track_start;
   } req_type;

   typedef struct packed {
      logic [2:0]       kind;
      logic [LEN_W-1:0] delta_time;
      logic [7:0]       status;
      logic [3:0]       channel;
      logic [6:0]       data_first;
      logic [6:0]       data_second;
      logic [7:0]       meta_type;
      logic [LEN_W-1:0] payload_length;
      logic [7:0]       payload_byte;
      logic             last;
      logic             error;
   } rsp_type;

   // classified byte as it travels from front to back
   typedef struct packed {
      logic [7:0] in_byte;
      logic       track_start;
      logic       is_status;
      logic       is_meta;
      logic       is_sysex;
      logic       is_sys_other;
      logic       is_eot_type;
   } entry_type;

   // variable-length quantity step, saturating at LEN_MAX
   function automatic logic [LEN_W-1:0] vlq_add(logic [LEN_W-1:0] acc, logic [7:0] b);
      logic [LEN_W-1:0] res;
      if (acc[LEN_W-1:LEN_W-7] != 7'd0) begin
         res = LEN_MAX;
      end else begin
         res = {acc[LEN_W-8:0], b[6:0]};
      end
      return res;
   endfunction

endpackage

// ===== rtl/mtep_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_front
// Classifies incoming track bytes and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mtep_front
   import mtep_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_payload,
   output logic      head_valid,
   output entry_type head,
   input  logic      head_pop
);

   entry_type  q_ff [2];
   entry_type  q_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   entry_type  cls;

   always_comb begin
      cls.in_byte      = req_payload.in_byte;
      cls.track_start  = req_payload.track_start;
      cls.is_status    = req_payload.in_byte[7];
      cls.is_meta      = (req_payload.in_byte == ST_META);
      cls.is_sysex     = (req_payload.in_byte == ST_SYSEX) ||
                         (req_payload.in_byte == ST_ESCAPE);
      cls.is_sys_other = (req_payload.in_byte[7:4] == SYS_NIBBLE) &&
                         !cls.is_meta && !cls.is_sysex;
      cls.is_eot_type  = (req_payload.in_byte == META_EOT);
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != 2'd0);
   assign pop        = head_valid && head_pop;
   assign head       = q_ff[rd_ptr_ff];
   assign q_in       = cls;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers inconsistent with count");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |=> (count_ff != 2'd0)) else $error("pushed entry lost");

endmodule

// ===== rtl/mtep_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_back
// Track event state machine: decodes deltas, status, lengths and payload,
// and drives the result register.
// ----------------------------------------------------------------------------
module mtep_back
   import mtep_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head,
   output logic      head_pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_payload
);

   typedef enum logic [3:0] {
      PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_MTYPE,
      PH_MLEN, PH_SLEN, PH_MPAY, PH_SPAY, PH_DONE
   } phase_type;

   phase_type        phase_ff, phase_in, phase_cur;
   logic [LEN_W-1:0] delta_ff, delta_in, delta_cur;
   logic [7:0]       rs_ff, rs_in, rs_cur;
   logic [7:0]       mtype_ff, mtype_in, mtype_cur;
   logic [LEN_W-1:0] len_ff, len_in, len_cur;
   logic [LEN_W-1:0] rem_ff, rem_in, rem_cur;
   logic [6:0]       first_ff, first_in, first_cur;
   logic             eot_ff, eot_in, eot_cur;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             take;
   logic             emit;
   logic             one_data;
   logic [LEN_W-1:0] len_new;
   logic [LEN_W-1:0] rem_dec;
   logic             is_meta_ph;
   logic [7:0]       b;

   assign head_pop    = !rsp_valid_ff || !rsp_stall;
   assign take        = head_valid && head_pop;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign b           = head.in_byte;

   always_comb begin
      if (head.track_start) begin
         phase_cur = PH_DELTA;
         delta_cur = '0;
         rs_cur    = 8'd0;
         mtype_cur = 8'd0;
         len_cur   = '0;
         rem_cur   = '0;
         first_cur = 7'd0;
         eot_cur   = 1'b0;
      end else begin
         phase_cur = phase_ff;
         delta_cur = delta_ff;
         rs_cur    = rs_ff;
         mtype_cur = mtype_ff;
         len_cur   = len_ff;
         rem_cur   = rem_ff;
         first_cur = first_ff;
         eot_cur   = eot_ff;
      end
   end

   always_comb begin
      phase_in   = phase_cur;
      delta_in   = delta_cur;
      rs_in      = rs_cur;
      mtype_in   = mtype_cur;
      len_in     = len_cur;
      rem_in     = rem_cur;
      first_in   = first_cur;
      eot_in     = eot_cur;
      emit       = 1'b0;
      rsp_in     = '0;
      rsp_in.delta_time = delta_cur;
      one_data   = (rs_cur[7:4] == CMD_PROG) || (rs_cur[7:4] == CMD_CHPRES);
      len_new    = vlq_add(len_cur, b);
      rem_dec    = (rem_cur != '0) ? rem_cur - 1'b1 : rem_cur;
      is_meta_ph = (phase_cur == PH_MLEN) || (phase_cur == PH_MPAY);

      unique case (phase_cur)
         PH_DELTA: begin
            delta_in = vlq_add(delta_cur, b);
            if (!b[7]) begin
               phase_in = PH_STATUS;
            end
         end
         PH_STATUS, PH_DATA1: begin
            if (phase_cur == PH_STATUS && head.is_status) begin
               if (head.is_meta) begin
                  rs_in    = 8'd0;
                  phase_in = PH_MTYPE;
               end else if (head.is_sysex) begin
                  rs_in    = 8'd0;
                  mtype_in = b;
                  len_in   = '0;
                  phase_in = PH_SLEN;
               end else if (head.is_sys_other) begin
                  rs_in    = 8'd0;
                  phase_in = PH_DELTA;
                  delta_in = '0;
               end else begin
                  rs_in    = b;
                  phase_in = PH_DATA1;
               end
            end else if (phase_cur == PH_STATUS && rs_cur == 8'd0) begin
               emit               = 1'b1;
               rsp_in.kind        = KIND_CHAN;
               rsp_in.data_first  = b[6:0];
               rsp_in.last        = 1'b1;
               rsp_in.error       = 1'b1;
               phase_in           = PH_DELTA;
               delta_in           = '0;
            end else begin
               first_in = b[6:0];
               if (one_data) begin
                  emit              = 1'b1;
                  rsp_in.kind       = KIND_CHAN;
                  rsp_in.status     = {rs_cur[7:4], 4'h0};
                  rsp_in.channel    = rs_cur[3:0];
                  rsp_in.data_first = b[6:0];
                  rsp_in.last       = 1'b1;
                  phase_in          = PH_DELTA;
                  delta_in          = '0;
               end else begin
                  phase_in = PH_DATA2;
               end
            end
         end
         PH_DATA2: begin
            emit               = 1'b1;
            rsp_in.kind        = KIND_CHAN;
            rsp_in.status      = {rs_cur[7:4], 4'h0};
            rsp_in.channel     = rs_cur[3:0];
            rsp_in.data_first  = first_cur;
            rsp_in.data_second = b[6:0];
            rsp_in.last        = 1'b1;
            phase_in           = PH_DELTA;
            delta_in           = '0;
         end
         PH_MTYPE: begin
            mtype_in = b;
            eot_in   = head.is_eot_type;
            len_in   = '0;
            phase_in = PH_MLEN;
         end
         PH_MLEN, PH_SLEN: begin
            len_in = len_new;
            if (!b[7]) begin
               emit                  = 1'b1;
               rsp_in.payload_length = len_new;
               rsp_in.last           = (len_new == '0);
               if (is_meta_ph) begin
                  rsp_in.kind      = eot_cur ? KIND_EOT : KIND_META;
                  rsp_in.status    = ST_META;
                  rsp_in.meta_type = mtype_cur;
               end else begin
                  rsp_in.kind   = KIND_SYSEX;
                  rsp_in.status = mtype_cur;
               end
               if (len_new == '0) begin
                  if (is_meta_ph && eot_cur) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_DELTA;
                     delta_in = '0;
                  end
               end else begin
                  rem_in   = len_new;
                  phase_in = is_meta_ph ? PH_MPAY : PH_SPAY;
               end
            end
         end
         PH_MPAY, PH_SPAY: begin
            rem_in                = rem_dec;
            emit                  = 1'b1;
            rsp_in.kind           = KIND_PAYLOAD;
            rsp_in.payload_length = len_cur;
            rsp_in.payload_byte   = b;
            rsp_in.last           = (rem_dec == '0);
            if (is_meta_ph) begin
               rsp_in.status    = ST_META;
               rsp_in.meta_type = mtype_cur;
            end else begin
               rsp_in.status = mtype_cur;
            end
            if (rem_dec == '0) begin
               if (is_meta_ph && eot_cur) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_DELTA;
                  delta_in = '0;
               end
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      rsp_valid_in = take ? emit : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DELTA;
         delta_ff     <= '0;
         rs_ff        <= 8'd0;
         mtype_ff     <= 8'd0;
         len_ff       <= '0;
         rem_ff       <= '0;
         first_ff     <= 7'd0;
         eot_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            delta_ff <= delta_in;
            rs_ff    <= rs_in;
            mtype_ff <= mtype_in;
            len_ff   <= len_in;
            rem_ff   <= rem_in;
            first_ff <= first_in;
            eot_ff   <= eot_in;
         end
         if (take && emit) begin
            rsp_ff <= rsp_in;
         end
      end
   end

   a_pay_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MPAY || phase_ff == PH_SPAY) |-> (rem_ff != '0))
      else $error("payload phase with nothing remaining");

   a_data2_status: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA2) |-> rs_ff[7])
      else $error("second data byte expected without running status");

   a_eot_done: assert property (@(posedge clock) disable iff (reset)
      (take && emit && rsp_in.last && (rsp_in.kind == KIND_EOT ||
       (rsp_in.kind == KIND_PAYLOAD && rsp_in.status == ST_META && eot_cur)))
      |=> (phase_ff == PH_DONE))
      else $error("end of track did not stop parsing");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.error) |->
      (rsp_ff.status == 8'd0 && rsp_ff.last && rsp_ff.kind == KIND_CHAN))
      else $error("malformed orphan data result");

endmodule

// ===== rtl/midi_track_event_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser_top
// Standard MIDI file track body parser: one byte per request, at most one
// result per byte.
// ----------------------------------------------------------------------------
// Bytes of a track body enter one per request and are classified into a
// two-entry queue; the event state machine takes one queued byte per cycle
// and loads the result register. Throughput is one byte per clock when the
// result side does not stall. A byte that yields a result is written into
// the queue and then loaded into the result register, which drives
// rsp_valid. Bytes that yield no result (delta bytes, status, meta type,
// length bytes but the last) are consumed silently; set track_start on the
// first byte of a new track.
module midi_track_event_parser_top
   import mtep_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic      head_valid;
   logic      head_pop;
   entry_type head;

   mtep_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .head_valid  (head_valid),
      .head        (head),
      .head_pop    (head_pop)
   );

   mtep_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .head_pop    (head_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
